>>> src/edcc_pkg.sv
package edcc_pkg;

   // Event codes carried in the request opcode field.
   typedef enum logic [1:0] {
      OP_PIN_CHANGE = 2'd0,
      OP_BLINK_TICK = 2'd1,
      OP_SECOND_TICK = 2'd2,
      OP_HOLD_TICK  = 2'd3
   } opcode_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_LONG_PRESS = 1'b0,
      CSR_BLINK_HALF = 1'b1
   } csr_index_type;

   localparam int CSR_DATA_W = 8;

   localparam logic [7:0] LONG_PRESS_RESET = 8'd122;
   localparam logic [7:0] BLINK_HALF_RESET = 8'd122;
   localparam logic [7:0] COUNT_MAX        = 8'd255;
   localparam logic [3:0] DIGIT_MAX        = 4'd9;
   localparam logic [3:0] DIGIT_RESET      = 4'd1;

   typedef struct packed {
      logic [7:0] high;
      logic       low;
   } segment_type;

   function automatic segment_type digit_glyph(input logic [3:0] d);
      segment_type s;
      case (d)
         4'd0:    s = '{high: 8'hFC, low: 1'b0};
         4'd1:    s = '{high: 8'h18, low: 1'b0};
         4'd2:    s = '{high: 8'h6C, low: 1'b1};
         4'd3:    s = '{high: 8'h3C, low: 1'b1};
         4'd4:    s = '{high: 8'h98, low: 1'b1};
         4'd5:    s = '{high: 8'hB4, low: 1'b1};
         4'd6:    s = '{high: 8'hF0, low: 1'b1};
         4'd7:    s = '{high: 8'h1C, low: 1'b0};
         4'd8:    s = '{high: 8'hFC, low: 1'b1};
         default: s = '{high: 8'h9C, low: 1'b1};
      endcase
      return s;
   endfunction

   function automatic segment_type mode_glyph(input logic auto_mode);
      segment_type s;
      s.high = auto_mode ? 8'hDC : 8'hD8;
      s.low  = 1'b1;
      return s;
   endfunction

   function automatic logic [3:0] digit_up(input logic [3:0] d);
      return (d >= DIGIT_MAX) ? 4'd0 : d + 4'd1;
   endfunction

   function automatic logic [3:0] digit_down(input logic [3:0] d);
      return (d == 4'd0 || d > DIGIT_MAX) ? DIGIT_MAX : d - 4'd1;
   endfunction

endpackage

>>> src/edcc_req_if.sv
interface edcc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic       switch_level;
   logic       data_level;
   logic       clock_level;

   modport source (output valid, opcode, switch_level, data_level, clock_level,
                   input ready);
   modport sink   (input valid, opcode, switch_level, data_level, clock_level,
                   output ready);
endinterface

>>> src/edcc_rsp_if.sv
interface edcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] digit;
   logic       auto_mode;
   logic       selecting;
   logic [7:0] segments_high;
   logic       segment_low;
   logic       indicator;

   modport source (output valid, digit, auto_mode, selecting, segments_high,
                   segment_low, indicator, input ready);
   modport sink   (input valid, digit, auto_mode, selecting, segments_high,
                   segment_low, indicator, output ready);
endinterface

>>> src/encoder_digit_counter_control_unit.sv
// Pipeline: a request passes the input register, then the state update and the
//   response register; both hold while the response side stalls.
// Throughput: one request per cycle while the response side is not stalled; the
//   state update in the second stage sets this figure.
// Reset: synchronous, active high; digit 1, manual mode, no selection, LED on,
//   both timing registers 122; the pipeline is emptied.
module encoder_digit_counter_control_unit
   import edcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   edcc_req_if.sink              req_chan,
   edcc_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // configuration
   logic [7:0] long_press_ff;
   logic [7:0] blink_half_ff;

   // input stage
   logic       in_valid_ff;
   opcode_type op_ff;
   logic       sw_ff;
   logic       data_ff;
   logic       clk_ff;

   // block state
   logic [3:0] digit_ff,  digit_in;
   logic       auto_ff,   auto_in;
   logic       select_ff, select_in;
   logic       swprev_ff, swprev_in;
   logic [7:0] hold_ff,   hold_in;
   logic       armed_ff,  armed_in;
   logic [7:0] blink_ff,  blink_in;
   logic       led_ff,    led_in;

   // output stage
   logic        out_valid_ff;
   logic [3:0]  out_digit_ff;
   logic        out_auto_ff;
   logic        out_select_ff;
   segment_type out_seg_ff;
   logic        out_led_ff;

   logic        advance;
   logic        take;
   logic [7:0]  hold_inc;
   logic [7:0]  blink_inc;
   logic [3:0]  digit_clamp;
   segment_type seg_in;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= LONG_PRESS_RESET;
         blink_half_ff <= BLINK_HALF_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_LONG_PRESS: long_press_ff <= csr_wr_data;
            CSR_BLINK_HALF: blink_half_ff <= csr_wr_data;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         op_ff   <= opcode_type'(req_chan.opcode);
         sw_ff   <= req_chan.switch_level;
         data_ff <= req_chan.data_level;
         clk_ff  <= req_chan.clock_level;
      end
   end

   assign hold_inc  = (hold_ff  < COUNT_MAX) ? hold_ff  + 8'd1 : hold_ff;
   assign blink_inc = (blink_ff < COUNT_MAX) ? blink_ff + 8'd1 : blink_ff;

   always_comb begin
      digit_in  = digit_ff;
      auto_in   = auto_ff;
      select_in = select_ff;
      swprev_in = swprev_ff;
      hold_in   = hold_ff;
      armed_in  = armed_ff;
      blink_in  = blink_ff;
      led_in    = led_ff;
      case (op_ff)
         OP_PIN_CHANGE: begin
            if (!sw_ff && swprev_ff) begin
               hold_in  = 8'd0;
               armed_in = 1'b1;
            end else if (sw_ff && !swprev_ff) begin
               armed_in = 1'b0;
               // short press: toggle selection, leaving it restores the LED
               if (hold_ff < long_press_ff) begin
                  hold_in   = 8'd0;
                  select_in = !select_ff;
                  if (select_ff) begin
                     blink_in = 8'd0;
                     led_in   = 1'b1;
                  end
               end
            end
            swprev_in = sw_ff;
            if (!clk_ff) begin
               if (select_in) begin
                  auto_in = !auto_ff;
               end else if (!auto_ff) begin
                  digit_in = data_ff ? digit_up(digit_ff) : digit_down(digit_ff);
               end
            end
         end
         OP_BLINK_TICK: begin
            if (select_ff) begin
               if (blink_inc >= blink_half_ff) begin
                  led_in   = !led_ff;
                  blink_in = 8'd0;
               end else begin
                  blink_in = blink_inc;
               end
            end
         end
         OP_SECOND_TICK: begin
            if (auto_ff) begin
               digit_in = digit_up(digit_ff);
            end
         end
         default: begin
            if (armed_ff) begin
               hold_in = hold_inc;
               // long press: saturate, disarm and flip the mode
               if (hold_inc >= long_press_ff && !sw_ff) begin
                  hold_in  = COUNT_MAX;
                  armed_in = 1'b0;
                  auto_in  = !auto_ff;
               end
            end
         end
      endcase
   end

   assign digit_clamp = (digit_in > DIGIT_MAX) ? DIGIT_MAX : digit_in;
   assign seg_in      = select_in ? mode_glyph(auto_in) : digit_glyph(digit_clamp);

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff     <= DIGIT_RESET;
         auto_ff      <= 1'b0;
         select_ff    <= 1'b0;
         swprev_ff    <= 1'b1;
         hold_ff      <= 8'd0;
         armed_ff     <= 1'b0;
         blink_ff     <= 8'd0;
         led_ff       <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            digit_ff  <= digit_in;
            auto_ff   <= auto_in;
            select_ff <= select_in;
            swprev_ff <= swprev_in;
            hold_ff   <= hold_in;
            armed_ff  <= armed_in;
            blink_ff  <= blink_in;
            led_ff    <= led_in;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
      if (take) begin
         out_digit_ff  <= digit_in;
         out_auto_ff   <= auto_in;
         out_select_ff <= select_in;
         out_seg_ff    <= seg_in;
         out_led_ff    <= select_in ? led_in : 1'b1;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.digit         = out_digit_ff;
   assign rsp_chan.auto_mode     = out_auto_ff;
   assign rsp_chan.selecting     = out_select_ff;
   assign rsp_chan.segments_high = out_seg_ff.high;
   assign rsp_chan.segment_low   = out_seg_ff.low;
   assign rsp_chan.indicator     = out_led_ff;

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      digit_ff <= DIGIT_MAX)
      else $error("digit left the decimal range");

   a_idle_blink: assert property (@(posedge clock) disable iff (reset)
      !select_ff |-> (led_ff && blink_ff == 8'd0))
      else $error("blink state not restored outside selection");

   a_armed_pressed: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> !swprev_ff)
      else $error("hold counting armed while switch released");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(op_ff) && $stable(sw_ff)))
      else $error("input stage lost a stalled request");

endmodule
